// ----- hdl/dufd_pkg.sv -----
// ----------------------------------------------------------------------------
// Dark uniform frame detector package
// Field widths, register indexes, reset values and verdict codes shared by
// the interfaces and the modules of the detector.
// ----------------------------------------------------------------------------
package dufd_pkg;

  // Payload field widths.
  localparam int unsigned LUMA_W   = 8;
  localparam int unsigned REASON_W = 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BRIGHT_W   = 8;
  localparam int unsigned MEAN_W     = 8;
  localparam int unsigned VAR_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_LIMIT = 2'd2;

  localparam logic [BRIGHT_W-1:0] BRIGHT_LIMIT_RST   = 8'd50;
  localparam logic [MEAN_W-1:0]   MEAN_LIMIT_RST     = 8'd16;
  localparam logic [VAR_W-1:0]    VARIANCE_LIMIT_RST = 16'd4;

  // Verdict codes.
  localparam logic [REASON_W-1:0] REASON_NONE     = 2'd0;
  localparam logic [REASON_W-1:0] REASON_BRIGHT   = 2'd1;
  localparam logic [REASON_W-1:0] REASON_MEAN     = 2'd2;
  localparam logic [REASON_W-1:0] REASON_VARIANCE = 2'd3;

  // Frames that may wait between the accumulator and the verdict unit.
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ----- hdl/dufd_pixel_if.sv -----
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one luma sample and the frame-end marker.
// ----------------------------------------------------------------------------
interface dufd_pixel_if import dufd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LUMA_W-1:0] luma;
  logic              frame_end;

  modport source (output valid, output luma, output frame_end, input ready);
  modport sink   (input valid, input luma, input frame_end, output ready);
endinterface

// ----- hdl/dufd_verdict_if.sv -----
// ----------------------------------------------------------------------------
// Verdict channel
// Valid/ready channel that carries the per-frame verdict.
// ----------------------------------------------------------------------------
interface dufd_verdict_if import dufd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                shutter_closed;
  logic [REASON_W-1:0] fail_reason;

  modport source (output valid, output shutter_closed, output fail_reason, input ready);
  modport sink   (input valid, input shutter_closed, input fail_reason, output ready);
endinterface

// ----- hdl/dark_uniform_frame_detector_unit.sv -----
// ----------------------------------------------------------------------------
// Dark uniform frame detector
// Per-frame verdict on whether a luma frame is dark and uniform.
// ----------------------------------------------------------------------------
// The pixel channel takes one luma word every cycle while the snapshot queue
// has room; the accumulator adds it to a saturating count, sum and sum of
// squares. On the word marked frame_end a snapshot goes into a two-frame
// queue and the verdict unit works it off: a frame with a bright pixel goes
// from the queue to the finish state and then into the output register, any
// other frame runs up to four products on a shared shift-and-add multiplier
// of W = clog2(MAX_PIXELS+1)+16 bits, which retires one bit per cycle and
// hands each product back to the sequencer. Pixels keep streaming while that
// runs; the pixel channel is held only while two finished frames wait in the
// queue behind the one being decided. Configuration writes take effect on the
// next cycle.
// ----------------------------------------------------------------------------
module dark_uniform_frame_detector_unit import dufd_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 4194304
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dufd_pixel_if.sink            pix_i,
  dufd_verdict_if.source        vrd_o
);

  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned FW = CW * 3 + 25;

  logic [BRIGHT_W-1:0] bright_limit_q, bright_limit_d;
  logic [MEAN_W-1:0]   mean_limit_q, mean_limit_d;
  logic [VAR_W-1:0]    variance_limit_q, variance_limit_d;

  logic          push, pop, empty, full;
  logic [FW-1:0] push_data, pop_data;

  // Configuration registers; unknown indexes are ignored.
  always_comb begin
    bright_limit_d   = bright_limit_q;
    mean_limit_d     = mean_limit_q;
    variance_limit_d = variance_limit_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BRIGHT_LIMIT:   bright_limit_d   = cfg_data_i[BRIGHT_W-1:0];
        CFG_MEAN_LIMIT:     mean_limit_d     = cfg_data_i[MEAN_W-1:0];
        CFG_VARIANCE_LIMIT: variance_limit_d = cfg_data_i[VAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_limit_q   <= BRIGHT_LIMIT_RST;
      mean_limit_q     <= MEAN_LIMIT_RST;
      variance_limit_q <= VARIANCE_LIMIT_RST;
    end else begin
      bright_limit_q   <= bright_limit_d;
      mean_limit_q     <= mean_limit_d;
      variance_limit_q <= variance_limit_d;
    end
  end

  // Accumulator.
  dufd_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bright_limit_i (bright_limit_q),
    .pix_i          (pix_i),
    .push_o         (push),
    .push_data_o    (push_data),
    .full_i         (full)
  );

  // Snapshot queue.
  dufd_fifo #(
    .WIDTH (FW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty),
    .full_o      (full)
  );

  // Verdict unit.
  dufd_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mean_limit_i     (mean_limit_q),
    .variance_limit_i (variance_limit_q),
    .empty_i          (empty),
    .pop_data_i       (pop_data),
    .pop_o            (pop),
    .vrd_o            (vrd_o)
  );

endmodule

// ----- hdl/dufd_front.sv -----
// ----------------------------------------------------------------------------
// Frame statistics accumulator
// Takes one pixel word per cycle unless the queue is full; keeps saturating
// count, sum, sum of squares and bright flag; pushes them on the last pixel.
// ----------------------------------------------------------------------------
module dufd_front import dufd_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 4194304
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [BRIGHT_W-1:0]                   bright_limit_i,
  dufd_pixel_if.sink                            pix_i,
  output logic                                  push_o,
  output logic [$clog2(MAX_PIXELS+1)*3+25-1:0]  push_data_o,
  input  logic                                  full_i
);

  localparam int unsigned CW  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SW  = CW + 8;
  localparam int unsigned SQW = CW + 16;

  logic [CW-1:0]  count_q, count_d, count_nx;
  logic [SW-1:0]  sum_q, sum_d, sum_nx;
  logic [SQW-1:0] sq_q, sq_d, sq_nx;
  logic           bright_q, bright_d, bright_nx;
  logic           accept;
  logic           room;
  logic [15:0]    square;

  // A word is taken whenever the queue has room for a possible snapshot.
  assign pix_i.ready = !full_i;
  assign accept      = pix_i.valid && !full_i;

  // Next statistics including the current pixel; the count saturates.
  assign square    = 16'(pix_i.luma) * 16'(pix_i.luma);
  assign room      = count_q < CW'(MAX_PIXELS);
  assign count_nx  = room ? count_q + CW'(1) : count_q;
  assign sum_nx    = room ? sum_q + SW'(pix_i.luma) : sum_q;
  assign sq_nx     = room ? sq_q + SQW'(square) : sq_q;
  assign bright_nx = bright_q || (pix_i.luma > bright_limit_i);

  assign push_o      = accept && pix_i.frame_end;
  assign push_data_o = {bright_nx, count_nx, sum_nx, sq_nx};

  // Accumulate, and clear after the last pixel of the frame.
  always_comb begin
    count_d  = count_q;
    sum_d    = sum_q;
    sq_d     = sq_q;
    bright_d = bright_q;
    if (accept) begin
      if (pix_i.frame_end) begin
        count_d  = '0;
        sum_d    = '0;
        sq_d     = '0;
        bright_d = 1'b0;
      end else begin
        count_d  = count_nx;
        sum_d    = sum_nx;
        sq_d     = sq_nx;
        bright_d = bright_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_q    <= '0;
      sq_q     <= '0;
      bright_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      sum_q    <= sum_d;
      sq_q     <= sq_d;
      bright_q <= bright_d;
    end
  end

  // The count never runs past the saturation point.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_PIXELS))
    else $error("pixel count above saturation point");

endmodule

// ----- hdl/dufd_fifo.sv -----
// ----------------------------------------------------------------------------
// Snapshot queue
// Small first-in first-out queue of frame statistics between the
// accumulator and the verdict unit.
// ----------------------------------------------------------------------------
module dufd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    fill_q, fill_d;
  logic             do_push, do_pop;

  assign empty_o    = fill_q == '0;
  assign full_o     = fill_q == NW'(DEPTH);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // Pointer and fill bookkeeping, wrapping at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + NW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // A snapshot offered to a full queue would be lost.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("snapshot pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("snapshot popped from an empty queue");

endmodule

// ----- hdl/dufd_serial_mul.sv -----
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle and
// pulses done when the full product is ready.
// ----------------------------------------------------------------------------
module dufd_serial_mul #(
  parameter int unsigned W = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] prod_o
);

  localparam int unsigned CNTW = $clog2(W + 1);

  logic [2*W-1:0] acc_q, acc_d;
  logic [2*W-1:0] sh_q, sh_d;
  logic [W-1:0]   b_q, b_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic           done_q, done_d;

  assign done_o = done_q;
  assign prod_o = acc_q;

  // One partial product is added per cycle while a product is in progress.
  always_comb begin
    acc_d  = acc_q;
    sh_d   = sh_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      sh_d  = (2*W)'(a_i);
      b_d   = b_i;
      cnt_d = CNTW'(W);
    end else if (cnt_q != '0) begin
      if (b_q[0]) begin
        acc_d = acc_q + sh_q;
      end
      sh_d   = {sh_q[2*W-2:0], 1'b0};
      b_d    = {1'b0, b_q[W-1:1]};
      cnt_d  = cnt_q - CNTW'(1);
      done_d = cnt_q == CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    b_q   <= b_d;
  end

  // A new product may only start once the previous one has finished.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> cnt_q == '0)
    else $error("multiplier restarted while busy");

endmodule

// ----- hdl/dufd_back.sv -----
// ----------------------------------------------------------------------------
// Verdict unit
// Takes one frame snapshot at a time, runs the bright check directly and the
// mean and variance checks on a shared serial multiplier, and holds the
// verdict word in an output register.
// ----------------------------------------------------------------------------
module dufd_back import dufd_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 4194304
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [MEAN_W-1:0]                     mean_limit_i,
  input  logic [VAR_W-1:0]                      variance_limit_i,
  input  logic                                  empty_i,
  input  logic [$clog2(MAX_PIXELS+1)*3+25-1:0]  pop_data_i,
  output logic                                  pop_o,
  dufd_verdict_if.source                        vrd_o
);

  localparam int unsigned CW  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SW  = CW + 8;
  localparam int unsigned SQW = CW + 16;
  localparam int unsigned OPW = SQW;
  localparam int unsigned PW  = 2 * OPW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  // Products taken in turn on the multiplier.
  localparam logic [1:0] OP_MEAN  = 2'd0;  // mean_limit * n
  localparam logic [1:0] OP_VBND  = 2'd1;  // (variance_limit + 1) * n
  localparam logic [1:0] OP_SQR   = 2'd2;  // s * s
  localparam logic [1:0] OP_CROSS = 2'd3;  // (sq - (variance_limit + 1) * n) * n

  logic [1:0]          state_q, state_d;
  logic [1:0]          op_q, op_d;
  logic [REASON_W-1:0] reason_q, reason_d;
  logic [CW-1:0]       n_q, n_d;
  logic [SW-1:0]       s_q, s_d;
  logic [SQW-1:0]      sq_q, sq_d;
  logic [PW-1:0]       bnd_q, bnd_d;
  logic [PW-1:0]       sqr_q, sqr_d;
  logic                out_valid_q, out_valid_d;
  logic [REASON_W-1:0] out_reason_q, out_reason_d;

  logic                snap_bright;
  logic [CW-1:0]       snap_n;
  logic [SW-1:0]       snap_s;
  logic [SQW-1:0]      snap_sq;
  logic                mul_start, mul_done;
  logic [OPW-1:0]      mul_a, mul_b;
  logic [PW-1:0]       mul_prod;
  logic [16:0]         vbound;

  assign {snap_bright, snap_n, snap_s, snap_sq} = pop_data_i;
  assign vbound = {1'b0, variance_limit_i} + 17'd1;

  dufd_serial_mul #(
    .W (OPW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Check sequencer. The variance test floor((sq - ceil(s*s/n)) / n) > V
  // is rewritten as sq >= (V+1)*n together with s*s <= (sq - (V+1)*n) * n.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    reason_d  = reason_q;
    n_d       = n_q;
    s_d       = s_q;
    sq_d      = sq_q;
    bnd_d     = bnd_q;
    sqr_d     = sqr_q;
    pop_o     = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    out_valid_d  = out_valid_q && !vrd_o.ready;
    out_reason_d = out_reason_q;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          n_d   = snap_n;
          s_d   = snap_s;
          sq_d  = snap_sq;
          if (snap_bright) begin
            reason_d = REASON_BRIGHT;
            state_d  = S_FIN;
          end else begin
            mul_start = 1'b1;
            mul_a     = OPW'(mean_limit_i);
            mul_b     = OPW'(snap_n);
            op_d      = OP_MEAN;
            state_d   = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          case (op_q)
            OP_MEAN: begin
              if (PW'(s_q) > mul_prod) begin
                reason_d = REASON_MEAN;
                state_d  = S_FIN;
              end else begin
                mul_start = 1'b1;
                mul_a     = OPW'(vbound);
                mul_b     = OPW'(n_q);
                op_d      = OP_VBND;
              end
            end
            OP_VBND: begin
              bnd_d     = mul_prod;
              mul_start = 1'b1;
              mul_a     = OPW'(s_q);
              mul_b     = OPW'(s_q);
              op_d      = OP_SQR;
            end
            OP_SQR: begin
              sqr_d = mul_prod;
              if (PW'(sq_q) < bnd_q) begin
                reason_d = REASON_NONE;
                state_d  = S_FIN;
              end else begin
                mul_start = 1'b1;
                mul_a     = sq_q - bnd_q[SQW-1:0];
                mul_b     = OPW'(n_q);
                op_d      = OP_CROSS;
              end
            end
            OP_CROSS: begin
              reason_d = (sqr_q <= mul_prod) ? REASON_VARIANCE : REASON_NONE;
              state_d  = S_FIN;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_FIN: begin
        if (!out_valid_q || vrd_o.ready) begin
          out_valid_d  = 1'b1;
          out_reason_d = reason_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_MEAN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reason_q     <= reason_d;
    n_q          <= n_d;
    s_q          <= s_d;
    sq_q         <= sq_d;
    bnd_q        <= bnd_d;
    sqr_q        <= sqr_d;
    out_reason_q <= out_reason_d;
  end

  // Output word.
  assign vrd_o.valid          = out_valid_q;
  assign vrd_o.fail_reason    = out_reason_q;
  assign vrd_o.shutter_closed = out_reason_q == REASON_NONE;

  // Products only come back while the sequencer waits for one.
  a_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_MUL)
    else $error("product returned outside the multiply state");

  // A held verdict is never overwritten before it is taken.
  a_verdict_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !vrd_o.ready) |=> (out_valid_q && $stable(out_reason_q)))
    else $error("pending verdict overwritten");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dark uniform frame detector testbench
// Streams luma frames through the detector under several limit settings and
// checks every verdict against an in-bench prediction of the frame statistics.
// ----------------------------------------------------------------------------
module testbench;
  import dufd_pkg::*;

  // A small frame cap keeps saturation reachable and verdicts short.
  localparam int unsigned FRAME_CAP     = 40;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned HOLD_SETTING  = 4;
  localparam int unsigned RANDOM_PIXELS = 800;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // Index past the last register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic              frame_end;
  } pixel_word_t;

  typedef struct packed {
    logic                shutter_closed;
    logic [REASON_W-1:0] fail_reason;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dufd_pixel_if   pix_if ();
  dufd_verdict_if vrd_if ();

  dark_uniform_frame_detector_unit #(
    .MAX_PIXELS (FRAME_CAP)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .vrd_o      (vrd_if)
  );

  // Shadow copy of the limit registers.
  logic [BRIGHT_W-1:0] bright_lim = BRIGHT_LIMIT_RST;
  logic [MEAN_W-1:0]   mean_lim   = MEAN_LIMIT_RST;
  logic [VAR_W-1:0]    var_lim    = VARIANCE_LIMIT_RST;

  // Running statistics of the frame in flight.
  logic [63:0] frame_pixels = '0;
  logic [63:0] frame_sum    = '0;
  logic [63:0] frame_sq_sum = '0;
  logic        frame_bright = 1'b0;

  pixel_word_t pending_pixels [$];
  verdict_t    expected_verdicts [$];

  int unsigned queued_pixels = 0;
  int unsigned pixels_taken  = 0;
  int unsigned frames_taken  = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned reason_tally [4] = '{0, 0, 0, 0};

  logic pix_fire_q;
  logic vrd_fire_q;
  bit   holding = 1'b0;

  int unsigned send_gap   = 0;
  int unsigned send_burst = 0;
  int unsigned take_gap   = 0;
  int unsigned take_burst = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  // Floor of the exact population variance, kept in integers:
  // floor((sq - ceil(s*s/n)) / n).
  function automatic logic [63:0] floor_variance(input logic [63:0] n,
                                                 input logic [63:0] s,
                                                 input logic [63:0] sq);
    logic [63:0] s2;
    logic [63:0] c;
    if (n == 0) return '0;
    s2 = s * s;
    c  = s2 / n + ((s2 % n) != 0 ? 64'd1 : 64'd0);
    if (c >= sq) return '0;
    return (sq - c) / n;
  endfunction

  // Adds one accepted word to the frame statistics and, on the last pixel,
  // queues the verdict the detector should give.
  function automatic void fold_pixel(input pixel_word_t w);
    verdict_t v;
    if (w.luma > bright_lim) frame_bright = 1'b1;
    if (frame_pixels < FRAME_CAP) begin
      frame_pixels = frame_pixels + 64'd1;
      frame_sum    = frame_sum + 64'(w.luma);
      frame_sq_sum = frame_sq_sum + 64'(w.luma) * 64'(w.luma);
    end
    if (w.frame_end) begin
      if (frame_bright)
        v.fail_reason = REASON_BRIGHT;
      else if (frame_sum > 64'(mean_lim) * frame_pixels)
        v.fail_reason = REASON_MEAN;
      else if (floor_variance(frame_pixels, frame_sum, frame_sq_sum) > 64'(var_lim))
        v.fail_reason = REASON_VARIANCE;
      else
        v.fail_reason = REASON_NONE;
      v.shutter_closed = (v.fail_reason == REASON_NONE);
      expected_verdicts.push_back(v);
      reason_tally[v.fail_reason]++;
      frame_pixels = '0;
      frame_sum    = '0;
      frame_sq_sum = '0;
      frame_bright = 1'b0;
    end
  endfunction

  // Idle length after a word: mostly none or short, a few long, and now and
  // then a burst of back-to-back words.
  function automatic int unsigned pick_gap(inout int unsigned burst);
    int unsigned roll;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    roll = $urandom_range(99, 0);
    if (roll < 2) begin
      burst = $urandom_range(60, 20);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  function automatic void push_pixel(input int unsigned luma, input bit last);
    pixel_word_t w;
    w.luma      = luma[LUMA_W-1:0];
    w.frame_end = last;
    pending_pixels.push_back(w);
    queued_pixels++;
  endfunction

  // One random frame shaped around the current limits: mostly dark and
  // nearly flat, some near the mean limit, some noisy, some with a spike.
  task automatic queue_random_frame();
    int unsigned len;
    int unsigned roll;
    int unsigned kind;
    int unsigned lo;
    int unsigned hi;
    int unsigned spike_at;
    int unsigned k;
    logic [LUMA_W-1:0] spike;
    roll = $urandom_range(99, 0);
    if (roll < 80)      len = $urandom_range(16, 1);
    else if (roll < 92) len = $urandom_range(FRAME_CAP, 17);
    else                len = $urandom_range(FRAME_CAP + 20, FRAME_CAP + 1);
    kind = $urandom_range(9, 0);
    if (kind <= 4) begin
      lo = $urandom_range(mean_lim, 0);
      hi = lo + $urandom_range(6, 0);
    end else if (kind <= 6) begin
      lo = (mean_lim >= 1) ? mean_lim - 1 : 0;
      hi = mean_lim + 1;
    end else if (kind <= 8) begin
      lo = 0;
      hi = 255;
    end else begin
      lo = 0;
      hi = $urandom_range(255, 0);
    end
    if (hi > 255) hi = 255;
    spike_at = ($urandom_range(4, 0) == 0) ? $urandom_range(len - 1, 0) : len;
    spike    = LUMA_W'($urandom_range(255, bright_lim));
    for (k = 0; k < len; k++) begin
      push_pixel((k == spike_at) ? 32'(spike) : $urandom_range(hi, lo), k == len - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    case (idx)
      CFG_BRIGHT_LIMIT:   bright_lim = data[BRIGHT_W-1:0];
      CFG_MEAN_LIMIT:     mean_lim   = data[MEAN_W-1:0];
      CFG_VARIANCE_LIMIT: var_lim    = data[VAR_W-1:0];
      default: ;
    endcase
  endtask

  // Upper data bits of the narrow registers carry junk that must be dropped.
  task automatic program_limits(input logic [BRIGHT_W-1:0] b,
                                input logic [MEAN_W-1:0] m,
                                input logic [VAR_W-1:0] v);
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    write_reg(CFG_BRIGHT_LIMIT, {8'($urandom), b});
    write_reg(CFG_MEAN_LIMIT, {8'($urandom), m});
    write_reg(CFG_VARIANCE_LIMIT, v);
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // Waits until every word is taken and every verdict is in, then lets the
  // verdict unit run out.
  task automatic drain_and_settle();
    while (pending_pixels.size() != 0 || pix_if.valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel sender: a word stays up until taken, then the next one follows
  // after a random gap.
  always @(negedge clk) begin : pixel_sender
    pixel_word_t w;
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_fire_q) begin
      if (send_gap > 0) begin
        send_gap--;
        pix_if.valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        w = pending_pixels.pop_front();
        pix_if.valid     <= 1'b1;
        pix_if.luma      <= w.luma;
        pix_if.frame_end <= w.frame_end;
        send_gap = pick_gap(send_burst);
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Verdict receiver: waits a random gap, often none, after each taken word,
  // and stalls for a long stretch while the hold-off is active.
  always @(negedge clk) begin
    if (!rst_n) begin
      vrd_if.ready <= 1'b0;
    end else begin
      if (vrd_fire_q) take_gap = pick_gap(take_burst);
      if (holding) begin
        vrd_if.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        vrd_if.ready <= 1'b0;
      end else begin
        vrd_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off at the start of a limit setting, while a full
  // batch of words is still waiting, so that finished frames pile up and
  // the pixel channel backs up.
  initial begin
    while (settings_used < HOLD_SETTING) @(posedge clk);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  // Monitor: checks each verdict word against the oldest prediction and
  // feeds each accepted pixel word to the predictor.
  always @(posedge clk) begin : monitor
    verdict_t want;
    if (!rst_n) begin
      pix_fire_q <= 1'b0;
      vrd_fire_q <= 1'b0;
    end else begin
      cycle_count++;
      pix_fire_q <= pix_if.valid && pix_if.ready;
      vrd_fire_q <= vrd_if.valid && vrd_if.ready;
      if (vrd_if.valid && vrd_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict with no frame pending");
        end else begin
          want = expected_verdicts.pop_front();
          if (vrd_if.shutter_closed !== want.shutter_closed)
            report_mismatch($sformatf("shutter_closed %b, expected %b",
                                      vrd_if.shutter_closed, want.shutter_closed));
          if (vrd_if.fail_reason !== want.fail_reason)
            report_mismatch($sformatf("fail_reason %0d, expected %0d",
                                      vrd_if.fail_reason, want.fail_reason));
        end
      end
      if (pix_if.valid && pix_if.ready) begin
        pixels_taken++;
        if (pix_if.frame_end) frames_taken++;
        fold_pixel('{luma: pix_if.luma, frame_end: pix_if.frame_end});
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles.", cycle_count);
    $display("[dark_uniform_frame_detector_unit] ERROR");
    $finish;
  end

  // Stimulus.
  initial begin
    int unsigned phase;
    int unsigned target;
    pix_if.valid     = 1'b0;
    pix_if.luma      = '0;
    pix_if.frame_end = 1'b0;
    vrd_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    rst_n            = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed frames at the reset limits: single pixels at both ends,
    // a flat frame, a mean exactly at and above the limit, bright pixels at
    // and just past the limit, and variance at and above the limit.
    push_pixel(0, 1);
    push_pixel(255, 1);
    push_pixel(10, 0); push_pixel(10, 0); push_pixel(10, 0); push_pixel(10, 1);
    push_pixel(50, 0); push_pixel(0, 1);
    push_pixel(16, 0); push_pixel(16, 1);
    push_pixel(0, 0); push_pixel(8, 0); push_pixel(0, 0); push_pixel(8, 1);
    push_pixel(0, 0); push_pixel(4, 0); push_pixel(0, 0); push_pixel(4, 1);
    push_pixel(51, 1);
    drain_and_settle();

    // Random frames under a series of limit settings, extremes included.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_limits(BRIGHT_LIMIT_RST, MEAN_LIMIT_RST, VARIANCE_LIMIT_RST);
        1: program_limits(8'd255, 8'd255, 16'hFFFF);
        2: program_limits(8'd0, 8'd0, 16'd0);
        3: program_limits(8'd200, 8'd100, 16'd300);
        default: begin
          program_limits(BRIGHT_W'($urandom_range(255, 0)),
                         MEAN_W'($urandom_range(255, 0)),
                         ($urandom_range(1, 0) != 0) ? VAR_W'($urandom_range(64, 0))
                                                      : VAR_W'($urandom_range(65535, 0)));
        end
      endcase
      target = queued_pixels + RANDOM_PIXELS / PHASES;
      while (queued_pixels < target) queue_random_frame();
      drain_and_settle();
    end

    $display("Ran %0d pixels in %0d frames under %0d limit settings, frame cap %0d.",
             pixels_taken, frames_taken, settings_used, FRAME_CAP);
    $display("Verdicts: %0d closed, %0d bright, %0d mean, %0d variance; %0d mismatches.",
             reason_tally[REASON_NONE], reason_tally[REASON_BRIGHT],
             reason_tally[REASON_MEAN], reason_tally[REASON_VARIANCE], mismatches);
    if (mismatches == 0) begin
      $display("[dark_uniform_frame_detector_unit] OK");
    end else begin
      $display("[dark_uniform_frame_detector_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dufd_pkg.sv
hdl/dufd_pixel_if.sv
hdl/dufd_verdict_if.sv
hdl/dufd_front.sv
hdl/dufd_fifo.sv
hdl/dufd_serial_mul.sv
hdl/dufd_back.sv
hdl/dark_uniform_frame_detector_unit.sv
dv/testbench.sv
